// ----- rtl/lwkr_pkg.sv -----
// Shared types and constants for the longest-window-with-k-repeats block.
// No dependencies; every other file of the block imports this package.
package lwkr_pkg;

	// payload widths of the item and result channels
	localparam int unsigned VALUE_W = 10;
	localparam int unsigned LEN_W   = 11;

	// number of distinct codes the value field can carry
	localparam int unsigned VALUE_SPAN = 1 << VALUE_W;

	// reciprocal scaling used for the modulo reduction of the value
	localparam int unsigned RECIP_SHIFT = 20;

	// configuration port
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned PADDR_W = 1;
	localparam logic [PADDR_W-1:0] ADDR_MAX_REPEATS = 1'b0;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_RET_BUF,
		ST_RET_DEC,
		ST_DRAIN
	} lwkr_state_t;

endpackage

// ----- rtl/lwkr_in_if.sv -----
// Item channel: valid/ready handshake carrying one sequence element.
// Depends on lwkr_pkg for the field widths.
interface lwkr_in_if;
	import lwkr_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- rtl/lwkr_out_if.sv -----
// Result channel: valid/ready handshake carrying one result per item.
// Depends on lwkr_pkg for the field widths.
interface lwkr_out_if;
	import lwkr_pkg::*;

	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] window_length;
	logic [LEN_W-1:0] best_length;
	logic             final_res;
	logic             overflow;

	modport source (output valid, output window_length, output best_length,
		output final_res, output overflow, input ready);
	modport sink   (input valid, input window_length, input best_length,
		input final_res, input overflow, output ready);
endinterface

// ----- rtl/longest_window_k_repeats.sv -----
// Longest window with at most k repeats: per value, a count memory tracks
// occurrences inside a sliding window held in a window buffer memory; both
// are single-port-write, registered-read memories. An item passes through
// accept, count read and decide, plus a buffer read, a count read and a
// count write-back for every element retired from the window's left end.
// After an item marked last, the remaining window is retired element by
// element the same way. After reset a clearing pass zeroes all
// min(VALUE_RANGE, 1024) entries of the count memory, during which no
// item is accepted. Results sit in an output register, so the next item can
// be processed while a result waits to be taken.
// Depends on lwkr_pkg, lwkr_in_if, lwkr_out_if and lwkr_cfg.
module longest_window_k_repeats #(
	parameter int unsigned VALUE_RANGE  = 1024,
	parameter int unsigned WINDOW_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lwkr_in_if.sink                       items,
	lwkr_out_if.source                    results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lwkr_pkg::PADDR_W-1:0]  paddr,
	input  logic [lwkr_pkg::DATA_W-1:0]   pwdata,
	output logic [lwkr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import lwkr_pkg::*;

	// reduced values never exceed the value field's span
	localparam int unsigned CDEPTH = (VALUE_RANGE < VALUE_SPAN) ? VALUE_RANGE : VALUE_SPAN;
	localparam int unsigned CIW    = $clog2(CDEPTH);
	localparam int unsigned AW     = $clog2(WINDOW_DEPTH);
	localparam int unsigned PW     = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned RECIP  = (1 << RECIP_SHIFT) / VALUE_RANGE;
	localparam int unsigned PRODW  = VALUE_W + RECIP_SHIFT;
	localparam int unsigned REMW   = 28;

	// memories
	logic [PW-1:0]  cnt_mem [CDEPTH];
	logic [CIW-1:0] buf_mem [WINDOW_DEPTH];

	// control state
	lwkr_state_t    state_q, state_d;
	logic [CIW-1:0] clr_idx_q;
	logic [PW-1:0]  left_q, right_q, best_q;
	logic           out_valid_q;
	logic           fresh_q;
	logic           drain_q;

	// payload registers
	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] quot_q;
	logic               last_q;
	logic [CIW-1:0]     v_q;
	logic [PW-1:0]      cnt_v_q;
	logic [CIW-1:0]     ret_val_q;
	logic [PW-1:0]      cnt_rd_q;
	logic [CIW-1:0]     buf_rd_q;
	logic [LEN_W-1:0]   out_len_q, out_best_q;
	logic               out_final_q, out_ovf_q;

	// combinational
	logic [LEN_W-1:0]  limit;
	logic [PRODW-1:0]  quot_prod;
	logic [REMW-1:0]   rem_prod, rem_diff, rem_fix;
	logic [CIW-1:0]    v_red;
	logic [PW-1:0]     cnt_cur;
	logic [PW+LEN_W-1:0] cnt_wide, lim_wide;
	logic              full, has_items, need_ret, out_free;
	logic [PW-1:0]     len_now, len_new, res_len, res_best;
	logic [PW+LEN_W-1:0] len_wide, best_wide;
	logic              clr_last;
	logic              accept, res_load, admit, ret_start, drain_end;
	logic              cnt_we, cnt_re;
	logic [CIW-1:0]    cnt_waddr, cnt_raddr;
	logic [PW-1:0]     cnt_wdata;

	// configuration register
	lwkr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limit   (limit)
	);

	// value modulo VALUE_RANGE: quotient estimate at accept, fix-up in the cycle after
	assign quot_prod = PRODW'(items.value) * PRODW'(RECIP);
	assign rem_prod  = REMW'(quot_q) * REMW'(VALUE_RANGE);
	assign rem_diff  = REMW'(value_q) - rem_prod;
	assign rem_fix   = (rem_diff >= REMW'(VALUE_RANGE)) ? rem_diff - REMW'(VALUE_RANGE) : rem_diff;
	assign v_red     = rem_fix[CIW-1:0];

	// window decision
	assign cnt_cur   = fresh_q ? cnt_rd_q : cnt_v_q;
	assign cnt_wide  = {{LEN_W{1'b0}}, cnt_cur};
	assign lim_wide  = {{PW{1'b0}}, limit};
	assign full      = (right_q == PW'(WINDOW_DEPTH));
	assign has_items = (left_q < right_q);
	assign need_ret  = !full && (cnt_wide >= lim_wide) && has_items;
	assign out_free  = !out_valid_q || results.ready;
	assign len_now   = right_q - left_q;
	assign len_new   = right_q + PW'(1) - left_q;
	assign res_len   = full ? len_now : len_new;
	assign res_best  = (!full && (len_new > best_q)) ? len_new : best_q;
	assign len_wide  = {{LEN_W{1'b0}}, res_len};
	assign best_wide = {{LEN_W{1'b0}}, res_best};
	assign clr_last  = (clr_idx_q == CIW'(CDEPTH - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_last) state_d = ST_IDLE;
			ST_IDLE:    if (items.valid) state_d = ST_READ;
			ST_READ:    state_d = ST_CHECK;
			ST_CHECK: begin
				if (need_ret) state_d = ST_RET_BUF;
				else if (out_free) state_d = last_q ? ST_DRAIN : ST_IDLE;
			end
			ST_RET_BUF: state_d = ST_RET_DEC;
			ST_RET_DEC: state_d = drain_q ? ST_DRAIN : ST_CHECK;
			ST_DRAIN:   state_d = has_items ? ST_RET_BUF : ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		accept    = 1'b0;
		res_load  = 1'b0;
		admit     = 1'b0;
		ret_start = 1'b0;
		drain_end = 1'b0;
		unique case (state_q)
			ST_IDLE:  accept = items.valid;
			ST_CHECK: begin
				if (need_ret) begin
					ret_start = 1'b1;
				end else if (out_free) begin
					res_load = 1'b1;
					admit    = !full;
				end
			end
			ST_DRAIN: begin
				ret_start = has_items;
				drain_end = !has_items;
			end
			default: ;
		endcase
	end

	assign items.ready = (state_q == ST_IDLE);

	// count memory port selection
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = v_q;
		cnt_wdata = cnt_cur + PW'(1);
		cnt_re    = 1'b0;
		cnt_raddr = v_red;
		if (state_q == ST_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_idx_q;
			cnt_wdata = '0;
		end else if (admit) begin
			cnt_we = 1'b1;
		end else if (state_q == ST_RET_DEC) begin
			cnt_we    = 1'b1;
			cnt_waddr = ret_val_q;
			cnt_wdata = (cnt_rd_q != '0) ? cnt_rd_q - PW'(1) : cnt_rd_q;
		end
		if (state_q == ST_READ) begin
			cnt_re = 1'b1;
		end else if (state_q == ST_RET_BUF) begin
			cnt_re    = 1'b1;
			cnt_raddr = buf_rd_q;
		end
	end

	// count memory
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[cnt_raddr];
		end
	end

	// window buffer memory
	always_ff @(posedge clk) begin
		if (admit) begin
			buf_mem[right_q[AW-1:0]] <= v_q;
		end
		if (ret_start) begin
			buf_rd_q <= buf_mem[left_q[AW-1:0]];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			left_q      <= '0;
			right_q     <= '0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
			fresh_q     <= 1'b0;
			drain_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + CIW'(1);
			end
			// result register: a new result replaces a taken one
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_READ) begin
				fresh_q <= 1'b1;
			end else if (state_q == ST_CHECK) begin
				fresh_q <= 1'b0;
			end
			if (admit) begin
				right_q <= right_q + PW'(1);
				best_q  <= res_best;
			end
			if (state_q == ST_RET_DEC) begin
				left_q <= left_q + PW'(1);
			end
			if (res_load && last_q) begin
				drain_q <= 1'b1;
			end
			// end of sequence: window emptied, positions and best cleared
			if (drain_end) begin
				drain_q <= 1'b0;
				left_q  <= '0;
				right_q <= '0;
				best_q  <= '0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= items.value;
			last_q  <= items.last;
			quot_q  <= quot_prod[PRODW-1:RECIP_SHIFT];
		end
		if (state_q == ST_READ) begin
			v_q <= v_red;
		end
		if (state_q == ST_CHECK) begin
			cnt_v_q <= cnt_cur;
		end else if (state_q == ST_RET_DEC && !drain_q && ret_val_q == v_q && cnt_v_q != '0) begin
			// the retired element matches the incoming value
			cnt_v_q <= cnt_v_q - PW'(1);
		end
		if (state_q == ST_RET_BUF) begin
			ret_val_q <= buf_rd_q;
		end
		if (res_load) begin
			out_len_q   <= len_wide[LEN_W-1:0];
			out_best_q  <= best_wide[LEN_W-1:0];
			out_final_q <= last_q;
			out_ovf_q   <= full;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.window_length = out_len_q;
	assign results.best_length   = out_best_q;
	assign results.final_res     = out_final_q;
	assign results.overflow      = out_ovf_q;

endmodule

// ----- rtl/lwkr_cfg.sv -----
// APB-style configuration register for the repeat limit.
// Depends on lwkr_pkg; instantiated by longest_window_k_repeats.
module lwkr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lwkr_pkg::PADDR_W-1:0]  paddr,
	input  logic [lwkr_pkg::DATA_W-1:0]   pwdata,
	output logic [lwkr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [lwkr_pkg::LEN_W-1:0]    limit
);
	import lwkr_pkg::*;

	logic [LEN_W-1:0] max_repeats_q;
	logic             wr_en;
	logic             sel_max;

	assign pready = 1'b1;

	// address decode
	always_comb begin
		unique case (paddr)
			ADDR_MAX_REPEATS: sel_max = 1'b1;
			default:          sel_max = 1'b0;
		endcase
	end

	assign wr_en = psel && penable && pwrite && pready && sel_max;

	// register write on the access cycle of a write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_repeats_q <= LEN_W'(1);
		end else if (wr_en) begin
			max_repeats_q <= pwdata[LEN_W-1:0];
		end
	end

	// read data
	assign prdata = sel_max ? DATA_W'(max_repeats_q) : '0;

	// a limit of zero behaves as one
	assign limit = (max_repeats_q == '0) ? LEN_W'(1) : max_repeats_q;

endmodule
